// ----- design/escape_time_fractal_pixel_unit_defines.svh -----
// Assertion macros for the escape-time fractal pixel unit.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_UNIT_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_UNIT_DEFINES_SVH
`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define ETFP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("etfp assertion failed");
// Condition implies a consequence in the cycle after.
`define ETFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etfp assertion failed");
`else
`define ETFP_ASSERT(lbl, prop)
`define ETFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/etfp_pkg.sv -----
// Shared constants, types and fixed-point helpers of the fractal pixel unit.
`default_nettype none
package etfp_pkg;
	localparam int FRAC_BITS = 56;
	localparam int MAX_POWER = 16;
	localparam int DATA_W    = 64;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = 16;
	localparam int PWR_W     = 5;
	localparam int COLOR_W   = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JRE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JIM     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAXITER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POWER   = 3'd5;

	localparam logic [DATA_W-2:0] RADIUS_RESET  = (DATA_W-1)'(64'd4 << FRAC_BITS);
	localparam logic [CNT_W-1:0]  MAXITER_RESET = 16'd2000;
	localparam logic [PWR_W-1:0]  POWER_RESET   = 5'd2;
	localparam logic [PWR_W-1:0]  POWER_MAX     = PWR_W'(MAX_POWER);

	localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'hFF000000;
	// palette gains: 9, 15 and 8.5 times 255, scaled by 8, 8^2 and 8^3
	localparam logic [DATA_W-1:0] GAIN_R = DATA_W'(9 * 255 * 8);
	localparam logic [DATA_W-1:0] GAIN_G = DATA_W'(15 * 255 * 64);
	localparam logic [DATA_W-1:0] GAIN_B = DATA_W'(17 * 255 * 256);
	localparam logic [DATA_W-1:0] PAL_OFFSET = DATA_W'(8);

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

	// product does not fit the signed fixed-point word
	function automatic logic fx_ovf(input logic [PROD_W-1:0] p);
		logic [PROD_W-FRAC_BITS-DATA_W:0] top;
		top = p[PROD_W-1:FRAC_BITS+DATA_W-1];
		return !((&top) || (~|top));
	endfunction

	// product rescaled, floor rounding falls out of the two's complement slice
	function automatic logic [DATA_W-1:0] fx_res(input logic [PROD_W-1:0] p);
		return p[FRAC_BITS+DATA_W-1:FRAC_BITS];
	endfunction

	function automatic logic add_ovf(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input logic [DATA_W-1:0] r);
		return (a[DATA_W-1] == b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1]);
	endfunction

	function automatic logic sub_ovf(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input logic [DATA_W-1:0] r);
		return (a[DATA_W-1] != b[DATA_W-1]) && (r[DATA_W-1] != a[DATA_W-1]);
	endfunction
endpackage
`default_nettype wire

// ----- design/etfp_point_if.sv -----
// Input channel: one complex point per request.
`default_nettype none
interface etfp_point_if;
	logic        valid;
	logic        ready;
	logic [63:0] point_re;
	logic [63:0] point_im;
	modport source(output valid, output point_re, output point_im, input ready);
	modport sink(input valid, input point_re, input point_im, output ready);
endinterface
`default_nettype wire

// ----- design/etfp_result_if.sv -----
// Output channel: iteration count, limit flag and color per request.
`default_nettype none
interface etfp_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] iteration_count;
	logic        reached_limit;
	logic [31:0] color_word;
	modport source(output valid, output iteration_count, output reached_limit,
		output color_word, input ready);
	modport sink(input valid, input iteration_count, input reached_limit,
		input color_word, output ready);
endinterface
`default_nettype wire

// ----- design/escape_time_fractal_pixel_unit.sv -----
// Escape-time fractal pixel unit: iterates z = z^k + c per point, outputs count and color.
// One point is taken at a time and its result is held in an output register until taken;
// the next point is accepted while that result waits. All multiplications go through
// one shared 64x64 multiplier that takes each product through four 32x32 partial products,
// accumulate, sign fix-up and capture. An iteration at power 2 takes three products plus
// the check, test, update and count steps; at power k it takes two squares plus four
// products per complex multiply, k-1 times. The palette then takes seven products and
// three 8-step divisions; a point that reaches the limit skips it.
`default_nettype none
`include "escape_time_fractal_pixel_unit_defines.svh"
module escape_time_fractal_pixel_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	etfp_point_if.sink                               point,
	etfp_result_if.source                            pixel,
	input  wire logic                                wr_en,
	input  wire logic [etfp_pkg::CFG_IDX_W-1:0]      wr_idx,
	input  wire logic [etfp_pkg::DATA_W-1:0]         wr_data
);
	localparam int W = etfp_pkg::DATA_W;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CHK   = 5'd1;
	localparam logic [4:0] S_SQR   = 5'd2;
	localparam logic [4:0] S_SQI   = 5'd3;
	localparam logic [4:0] S_TEST  = 5'd4;
	localparam logic [4:0] S_XY    = 5'd5;
	localparam logic [4:0] S_UPD2  = 5'd6;
	localparam logic [4:0] S_M1    = 5'd7;
	localparam logic [4:0] S_M2    = 5'd8;
	localparam logic [4:0] S_M3    = 5'd9;
	localparam logic [4:0] S_M4    = 5'd10;
	localparam logic [4:0] S_FIN   = 5'd11;
	localparam logic [4:0] S_NEXT  = 5'd12;
	localparam logic [4:0] S_PAL   = 5'd13;
	localparam logic [4:0] S_P1    = 5'd14;
	localparam logic [4:0] S_P2    = 5'd15;
	localparam logic [4:0] S_P3    = 5'd16;
	localparam logic [4:0] S_P4    = 5'd17;
	localparam logic [4:0] S_P5    = 5'd18;
	localparam logic [4:0] S_P6    = 5'd19;
	localparam logic [4:0] S_P7    = 5'd20;
	localparam logic [4:0] S_DIVLD = 5'd21;
	localparam logic [4:0] S_DIV   = 5'd22;
	localparam logic [4:0] S_OUT   = 5'd23;

	localparam logic [1:0] CH_R = 2'd0;
	localparam logic [1:0] CH_G = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;

	// configuration registers
	logic                               mode_q;
	logic [W-1:0]                       jre_q, jim_q;
	logic [W-2:0]                       rad_q;
	logic [etfp_pkg::CNT_W-1:0]         maxit_q;
	logic [etfp_pkg::PWR_W-1:0]         pow_q;

	// control
	logic [4:0]                         state_q;
	logic                               pend_q;
	logic                               res_valid_q;

	// datapath
	logic [W-1:0]                       zr_q, zi_q, cr_q, ci_q;
	logic [W-1:0]                       r2_q, i2_q, ar_q, ai_q, p_q, q_q, s_q;
	logic                               ov_q, lim_q;
	logic [etfp_pkg::CNT_W-1:0]         iter_q;
	logic [etfp_pkg::PWR_W-1:0]         k_q, kcnt_q;
	logic [W:0]                         den_q;
	logic [W-1:0]                       rem_q;
	logic [2:0]                         bit_q;
	logic [1:0]                         ch_q;
	logic [7:0]                         quo_q, chr_q, chg_q, chb_q;
	logic [etfp_pkg::CNT_W-1:0]         res_cnt_q;
	logic                               res_lim_q;
	logic [etfp_pkg::COLOR_W-1:0]       res_color_q;

	// shared multiplier
	etfp_pkg::mul_req_t                 mul_req;
	etfp_pkg::mul_sts_t                 mul_sts;
	logic [etfp_pkg::PROD_W-1:0]        mul_prod;
	logic                               mul_state, mul_start, mul_fire;
	logic [W-1:0]                       fx, raw;
	logic                               fo;

	etfp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.sts    (mul_sts),
		.prod   (mul_prod)
	);

	logic [W-1:0]   n_val, d_val;
	logic [W-1:0]   t2, ni, dd, nr, sub_s, add_a, fin_r, fin_i;
	logic [W+1:0]   mag2;
	logic [W+8:0]   trial;
	logic [7:0]     quo_n;
	logic           accept, out_free;
	logic [etfp_pkg::PWR_W-1:0] k_clamp;

	assign n_val = W'(iter_q);
	assign d_val = W'(iter_q) + etfp_pkg::PAL_OFFSET;

	// operand select for the shared multiplier
	always_comb begin
		mul_state = 1'b1;
		mul_req.a = '0;
		mul_req.b = '0;
		case (state_q)
			S_SQR: begin mul_req.a = zr_q;  mul_req.b = zr_q; end
			S_SQI: begin mul_req.a = zi_q;  mul_req.b = zi_q; end
			S_XY:  begin mul_req.a = zr_q;  mul_req.b = zi_q; end
			S_M1:  begin mul_req.a = ar_q;  mul_req.b = zr_q; end
			S_M2:  begin mul_req.a = ai_q;  mul_req.b = zi_q; end
			S_M3:  begin mul_req.a = ar_q;  mul_req.b = zi_q; end
			S_M4:  begin mul_req.a = ai_q;  mul_req.b = zr_q; end
			S_P1:  begin mul_req.a = n_val; mul_req.b = n_val; end
			S_P2:  begin mul_req.a = p_q;   mul_req.b = n_val; end
			S_P3:  begin mul_req.a = q_q;   mul_req.b = etfp_pkg::GAIN_R; end
			S_P4:  begin mul_req.a = p_q;   mul_req.b = etfp_pkg::GAIN_G; end
			S_P5:  begin mul_req.a = n_val; mul_req.b = etfp_pkg::GAIN_B; end
			S_P6:  begin mul_req.a = d_val; mul_req.b = d_val; end
			S_P7:  begin mul_req.a = s_q;   mul_req.b = s_q; end
			default: begin mul_state = 1'b0; end
		endcase
		mul_start     = mul_state && !pend_q;
		mul_req.start = mul_start;
	end

	assign mul_fire = pend_q && mul_sts.done;
	assign fx       = etfp_pkg::fx_res(mul_prod);
	assign fo       = etfp_pkg::fx_ovf(mul_prod);
	assign raw      = mul_prod[W-1:0];

	// adders of the power-2 update, the generic complex step and the final add
	assign t2    = p_q + p_q;
	assign ni    = t2 + ci_q;
	assign dd    = r2_q - i2_q;
	assign nr    = dd + cr_q;
	assign sub_s = p_q - fx;
	assign add_a = p_q + fx;
	assign fin_r = ar_q + cr_q;
	assign fin_i = ai_q + ci_q;
	assign mag2  = (W+2)'(r2_q) + (W+2)'(i2_q);

	// restoring division step, quotient below 256
	assign trial = (W+9)'(rem_q) - ((W+9)'(den_q) << bit_q);
	always_comb begin
		quo_n = quo_q;
		if (!trial[W+8]) quo_n[bit_q] = 1'b1;
	end

	assign accept   = point.valid && point.ready;
	assign out_free = !res_valid_q || pixel.ready;

	// exponent: zero acts as one, large values clamp
	always_comb begin
		k_clamp = pow_q;
		if (pow_q == '0) k_clamp = etfp_pkg::PWR_W'(1);
		else if (pow_q > etfp_pkg::POWER_MAX) k_clamp = etfp_pkg::POWER_MAX;
	end

	// configuration writes, sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			jre_q       <= '0;
			jim_q       <= '0;
			rad_q       <= etfp_pkg::RADIUS_RESET;
			maxit_q     <= etfp_pkg::MAXITER_RESET;
			pow_q       <= etfp_pkg::POWER_RESET;
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_idx)
					etfp_pkg::REG_MODE:    mode_q  <= wr_data[0];
					etfp_pkg::REG_JRE:     jre_q   <= wr_data;
					etfp_pkg::REG_JIM:     jim_q   <= wr_data;
					etfp_pkg::REG_RADIUS:  rad_q   <= wr_data[W-2:0];
					etfp_pkg::REG_MAXITER: maxit_q <= wr_data[etfp_pkg::CNT_W-1:0];
					etfp_pkg::REG_POWER:   pow_q   <= wr_data[etfp_pkg::PWR_W-1:0];
					default: ;
				endcase
			end

			if (mul_start) pend_q <= 1'b1;
			else if (mul_fire) pend_q <= 1'b0;

			// a new result refills the register in the cycle the old one leaves
			if (state_q == S_OUT && out_free) res_valid_q <= 1'b1;
			else if (pixel.valid && pixel.ready) res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE:  if (accept) state_q <= S_CHK;
				S_CHK:   state_q <= (iter_q < maxit_q) ? S_SQR : S_PAL;
				S_SQR:   if (mul_fire) state_q <= fo ? S_PAL : S_SQI;
				S_SQI:   if (mul_fire) state_q <= fo ? S_PAL : S_TEST;
				S_TEST: begin
					if (mag2 > (W+2)'(rad_q)) state_q <= S_PAL;
					else if (k_q == etfp_pkg::PWR_W'(2)) state_q <= S_XY;
					else if (k_q == etfp_pkg::PWR_W'(1)) state_q <= S_FIN;
					else state_q <= S_M1;
				end
				S_XY:    if (mul_fire) state_q <= S_UPD2;
				S_UPD2:  state_q <= S_NEXT;
				S_M1:    if (mul_fire) state_q <= S_M2;
				S_M2:    if (mul_fire) state_q <= S_M3;
				S_M3:    if (mul_fire) state_q <= S_M4;
				S_M4:    if (mul_fire) state_q <= (kcnt_q == etfp_pkg::PWR_W'(1)) ? S_FIN : S_M1;
				S_FIN:   state_q <= S_NEXT;
				S_NEXT:  state_q <= ov_q ? S_PAL : S_CHK;
				S_PAL:   state_q <= (iter_q == maxit_q) ? S_OUT : S_P1;
				S_P1:    if (mul_fire) state_q <= S_P2;
				S_P2:    if (mul_fire) state_q <= S_P3;
				S_P3:    if (mul_fire) state_q <= S_P4;
				S_P4:    if (mul_fire) state_q <= S_P5;
				S_P5:    if (mul_fire) state_q <= S_P6;
				S_P6:    if (mul_fire) state_q <= S_P7;
				S_P7:    if (mul_fire) state_q <= S_DIVLD;
				S_DIVLD: state_q <= S_DIV;
				S_DIV: begin
					if (bit_q == 3'd0) state_q <= (ch_q == CH_B) ? S_OUT : S_DIVLD;
				end
				S_OUT:   if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					iter_q <= '0;
					k_q    <= k_clamp;
					if (mode_q) begin
						zr_q <= point.point_re;
						zi_q <= point.point_im;
						cr_q <= jre_q;
						ci_q <= jim_q;
					end else begin
						zr_q <= '0;
						zi_q <= '0;
						cr_q <= point.point_re;
						ci_q <= point.point_im;
					end
				end
			end
			S_SQR: if (mul_fire) r2_q <= fx;
			S_SQI: if (mul_fire) i2_q <= fx;
			S_TEST: begin
				ar_q   <= zr_q;
				ai_q   <= zi_q;
				kcnt_q <= k_q - etfp_pkg::PWR_W'(1);
				ov_q   <= 1'b0;
			end
			S_XY: begin
				if (mul_fire) begin
					p_q  <= fx;
					ov_q <= fo;
				end
			end
			// power 2: im' = 2xy + ci, re' = x^2 - y^2 + cr
			S_UPD2: begin
				zi_q <= ni;
				zr_q <= nr;
				ov_q <= ov_q || (p_q[W-1] != p_q[W-2]) || etfp_pkg::add_ovf(t2, ci_q, ni)
					|| etfp_pkg::sub_ovf(r2_q, i2_q, dd) || etfp_pkg::add_ovf(dd, cr_q, nr);
			end
			S_M1: begin
				if (mul_fire) begin
					p_q  <= fx;
					ov_q <= ov_q || fo;
				end
			end
			S_M2: begin
				if (mul_fire) begin
					s_q  <= sub_s;
					ov_q <= ov_q || fo || etfp_pkg::sub_ovf(p_q, fx, sub_s);
				end
			end
			S_M3: begin
				if (mul_fire) begin
					p_q  <= fx;
					ov_q <= ov_q || fo;
				end
			end
			S_M4: begin
				if (mul_fire) begin
					ai_q   <= add_a;
					ar_q   <= s_q;
					kcnt_q <= kcnt_q - etfp_pkg::PWR_W'(1);
					ov_q   <= ov_q || fo || etfp_pkg::add_ovf(p_q, fx, add_a);
				end
			end
			S_FIN: begin
				zr_q <= fin_r;
				zi_q <= fin_i;
				ov_q <= ov_q || etfp_pkg::add_ovf(ar_q, cr_q, fin_r)
					|| etfp_pkg::add_ovf(ai_q, ci_q, fin_i);
			end
			S_NEXT: iter_q <= iter_q + etfp_pkg::CNT_W'(1);
			S_PAL: begin
				lim_q <= (iter_q == maxit_q);
				ch_q  <= CH_R;
			end
			// palette numerators and d^4
			S_P1: if (mul_fire) p_q <= raw;
			S_P2: if (mul_fire) q_q <= raw;
			S_P3: if (mul_fire) zr_q <= raw;
			S_P4: if (mul_fire) zi_q <= raw;
			S_P5: if (mul_fire) ar_q <= raw;
			S_P6: if (mul_fire) s_q <= raw;
			S_P7: if (mul_fire) den_q <= mul_prod[W:0];
			S_DIVLD: begin
				rem_q <= (ch_q == CH_R) ? zr_q : ((ch_q == CH_G) ? zi_q : ar_q);
				bit_q <= 3'd7;
				quo_q <= '0;
			end
			S_DIV: begin
				if (!trial[W+8]) rem_q <= trial[W-1:0];
				quo_q <= quo_n;
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					case (ch_q)
						CH_R:    chr_q <= quo_n;
						CH_G:    chg_q <= quo_n;
						default: chb_q <= quo_n;
					endcase
					ch_q <= ch_q + 2'd1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					res_cnt_q   <= iter_q;
					res_lim_q   <= lim_q;
					res_color_q <= lim_q ? etfp_pkg::OPAQUE_BLACK
						: (etfp_pkg::OPAQUE_BLACK | {8'h00, chr_q, chg_q, chb_q});
				end
			end
			default: ;
		endcase
	end

	assign point.ready           = (state_q == S_IDLE);
	assign pixel.valid           = res_valid_q;
	assign pixel.iteration_count = res_cnt_q;
	assign pixel.reached_limit   = res_lim_q;
	assign pixel.color_word      = res_color_q;

	// checks
	`ETFP_ASSERT(a_mul_start_idle, mul_start |-> !mul_sts.busy)
	`ETFP_ASSERT(a_mul_done_owned, mul_sts.done |-> pend_q)
	`ETFP_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE)
	`ETFP_ASSERT(a_limit_black, (res_valid_q && res_lim_q) |-> (res_color_q == etfp_pkg::OPAQUE_BLACK))
endmodule
`default_nettype wire

// ----- design/etfp_mul.sv -----
// Multi-cycle signed 64x64 multiplier built from one 32x32 unsigned multiplier.
`default_nettype none
module etfp_mul (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire etfp_pkg::mul_req_t              req,
	output etfp_pkg::mul_sts_t                   sts,
	output logic [etfp_pkg::PROD_W-1:0]          prod
);
	localparam int HALF_W = etfp_pkg::DATA_W / 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_P0   = 3'd1;
	localparam logic [2:0] ST_P1   = 3'd2;
	localparam logic [2:0] ST_P2   = 3'd3;
	localparam logic [2:0] ST_P3   = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_SIGN = 3'd6;

	logic [2:0]                      step_q;
	logic                            done_q;
	logic [etfp_pkg::DATA_W-1:0]     ua_q, ub_q;
	logic                            neg_q;
	logic [etfp_pkg::PROD_W-1:0]     acc_q, prod_q;
	logic [etfp_pkg::DATA_W-1:0]     pp_q, pp_d;
	logic [1:0]                      sh_q, sh_d;
	logic [HALF_W-1:0]               opa, opb;

	// partial product selection per step
	always_comb begin
		opa  = ua_q[HALF_W-1:0];
		opb  = ub_q[HALF_W-1:0];
		sh_d = 2'd0;
		case (step_q)
			ST_P1: begin
				opb  = ub_q[etfp_pkg::DATA_W-1:HALF_W];
				sh_d = 2'd1;
			end
			ST_P2: begin
				opa  = ua_q[etfp_pkg::DATA_W-1:HALF_W];
				sh_d = 2'd1;
			end
			ST_P3: begin
				opa  = ua_q[etfp_pkg::DATA_W-1:HALF_W];
				opb  = ub_q[etfp_pkg::DATA_W-1:HALF_W];
				sh_d = 2'd2;
			end
			default: begin
				sh_d = 2'd0;
			end
		endcase
		pp_d = opa * opb;
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (step_q == ST_IDLE) begin
				if (req.start) step_q <= ST_P0;
			end else if (step_q == ST_SIGN) begin
				step_q <= ST_IDLE;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// magnitudes, accumulation and sign fix-up
	always_ff @(posedge clk) begin
		if (step_q == ST_IDLE && req.start) begin
			ua_q  <= req.a[etfp_pkg::DATA_W-1] ? (etfp_pkg::DATA_W'(0) - req.a) : req.a;
			ub_q  <= req.b[etfp_pkg::DATA_W-1] ? (etfp_pkg::DATA_W'(0) - req.b) : req.b;
			neg_q <= req.a[etfp_pkg::DATA_W-1] ^ req.b[etfp_pkg::DATA_W-1];
			acc_q <= '0;
		end
		if (step_q >= ST_P0 && step_q <= ST_P3) begin
			pp_q <= pp_d;
			sh_q <= sh_d;
		end
		if (step_q >= ST_P1 && step_q <= ST_ACC) begin
			acc_q <= acc_q + (etfp_pkg::PROD_W'(pp_q) << {sh_q, 5'b0});
		end
		if (step_q == ST_SIGN) begin
			prod_q <= neg_q ? (etfp_pkg::PROD_W'(0) - acc_q) : acc_q;
		end
	end

	assign sts.busy = (step_q != ST_IDLE);
	assign sts.done = done_q;
	assign prod     = prod_q;
endmodule
`default_nettype wire

// ----- verif/escape_time_fractal_pixel_unit_test.sv -----
// Self-checking testbench of the escape-time fractal pixel unit.
`timescale 1ns / 1ps
module escape_time_fractal_pixel_unit_test;
	typedef struct {
		logic [15:0] count;
		logic        at_limit;
		logic [31:0] color;
	} pixel_t;

	typedef struct {
		logic [63:0] re;
		logic [63:0] im;
	} point_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [etfp_pkg::CFG_IDX_W-1:0] wr_idx;
	logic [etfp_pkg::DATA_W-1:0] wr_data;

	etfp_point_if  pin();
	etfp_result_if pout();

	escape_time_fractal_pixel_unit dut (
		.clk(clk), .arst_n(arst_n), .point(pin), .pixel(pout),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	// shadow copy of the registers
	logic        cfg_mode;
	logic [63:0] cfg_jre;
	logic [63:0] cfg_jim;
	logic [62:0] cfg_radius;
	logic [15:0] cfg_maxit;
	logic [4:0]  cfg_power;

	point_t point_q[$];
	pixel_t pixel_q[$];
	int     n_errors = 0;
	int     n_points = 0;
	int     n_pixels = 0;
	int     n_inside = 0;
	bit     accepted = 0;
	int     burst_left = 0;
	int     gap_left = 0;
	int     stall_left = 0;
	bit     long_hold_req = 0;
	int     long_hold_left = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// fixed-point product, floor rounding; returns overflow
	function automatic logic fx_mul_chk(input logic [63:0] a, input logic [63:0] b,
			output logic [63:0] r);
		logic signed [127:0] sa;
		logic signed [127:0] sb;
		logic signed [127:0] p;
		sa = $signed(a);
		sb = $signed(b);
		p = sa * sb;
		r = p[119:56];
		return !((&p[127:119]) || (~|p[127:119]));
	endfunction

	function automatic logic fx_add_chk(input logic [63:0] a, input logic [63:0] b,
			output logic [63:0] r);
		r = a + b;
		return (a[63] == b[63]) && (r[63] != a[63]);
	endfunction

	function automatic logic fx_sub_chk(input logic [63:0] a, input logic [63:0] b,
			output logic [63:0] r);
		r = a - b;
		return (a[63] != b[63]) && (r[63] != a[63]);
	endfunction

	function automatic logic [7:0] palette_channel(input logic [63:0] num, input logic [63:0] d);
		logic [63:0] q;
		q = num / d;
		q = q / d;
		q = q / d;
		q = q / d;
		return q[7:0];
	endfunction

	// escape-time iteration and palette for one point
	function automatic pixel_t escape_pixel(input logic [63:0] pre, input logic [63:0] pim);
		pixel_t res;
		logic [63:0] zr, zi, cr, ci, r2, i2, nr, ni, t, ar, ai, p, q, s, n, d;
		logic [15:0] cnt;
		logic ov;
		int k;
		k = cfg_power;
		if (k == 0) k = 1;
		if (k > etfp_pkg::MAX_POWER) k = etfp_pkg::MAX_POWER;
		if (cfg_mode) begin
			zr = pre; zi = pim; cr = cfg_jre; ci = cfg_jim;
		end else begin
			zr = 0; zi = 0; cr = pre; ci = pim;
		end
		cnt = 0;
		while (cnt < cfg_maxit) begin
			if (fx_mul_chk(zr, zr, r2)) break;
			if (fx_mul_chk(zi, zi, i2)) break;
			if (r2 + i2 > {1'b0, cfg_radius}) break;
			if (k == 2) begin
				ov = fx_mul_chk(zr, zi, t);
				ov |= fx_add_chk(t, t, t);
				ov |= fx_add_chk(t, ci, ni);
				ov |= fx_sub_chk(r2, i2, t);
				ov |= fx_add_chk(t, cr, nr);
			end else begin
				ar = zr;
				ai = zi;
				ov = 0;
				for (int i = 1; i < k; i++) begin
					ov |= fx_mul_chk(ar, zr, p);
					ov |= fx_mul_chk(ai, zi, q);
					ov |= fx_sub_chk(p, q, s);
					ov |= fx_mul_chk(ar, zi, p);
					ov |= fx_mul_chk(ai, zr, q);
					ov |= fx_add_chk(p, q, ai);
					ar = s;
				end
				ov |= fx_add_chk(ar, cr, nr);
				ov |= fx_add_chk(ai, ci, ni);
			end
			zr = nr;
			zi = ni;
			cnt++;
			if (ov) break;
		end
		res.count = cnt;
		res.at_limit = (cnt == cfg_maxit);
		if (res.at_limit) begin
			res.color = etfp_pkg::OPAQUE_BLACK;
		end else begin
			n = cnt;
			d = n + 8;
			res.color = etfp_pkg::OPAQUE_BLACK | {8'h00, palette_channel(18360 * n * n * n, d),
				palette_channel(244800 * n * n, d), palette_channel(1109760 * n, d)};
		end
		return res;
	endfunction

	// note each accepted request and predict its pixel
	always @(posedge clk) begin
		if (arst_n && pin.valid && pin.ready) begin
			accepted = 1;
			n_points++;
			pixel_q.push_back(escape_pixel(pin.point_re, pin.point_im));
		end
	end

	// driver: bursts of requests with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			pin.valid <= 1'b0;
		end else if (!pin.valid || accepted) begin
			accepted = 0;
			if (gap_left > 0) begin
				gap_left--;
				pin.valid <= 1'b0;
			end else if (point_q.size() > 0) begin
				point_t pt;
				pt = point_q.pop_front();
				pin.valid <= 1'b1;
				pin.point_re <= pt.re;
				pin.point_im <= pt.im;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				pin.valid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			pout.ready <= 1'b0;
		end else if (long_hold_req || long_hold_left > 0) begin
			if (long_hold_req) begin
				long_hold_req = 0;
				long_hold_left = 3000;
			end else begin
				long_hold_left--;
			end
			pout.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			pout.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 60);
			pout.ready <= 1'b1;
		end
	end

	// monitor: compare each pixel with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pout.valid && pout.ready) begin
			n_pixels++;
			if (pixel_q.size() == 0) begin
				$error("pixel with no request outstanding");
				n_errors++;
			end else begin
				pixel_t e;
				e = pixel_q.pop_front();
				if (e.at_limit) n_inside++;
				if (pout.iteration_count !== e.count) begin
					$error("iteration_count expected %0d actual %0d", e.count,
						pout.iteration_count);
					n_errors++;
				end
				if (pout.reached_limit !== e.at_limit) begin
					$error("reached_limit expected %0b actual %0b", e.at_limit,
						pout.reached_limit);
					n_errors++;
				end
				if (pout.color_word !== e.color) begin
					$error("color_word expected %h actual %h", e.color, pout.color_word);
					n_errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic [etfp_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		case (idx)
			etfp_pkg::REG_MODE:    cfg_mode = val[0];
			etfp_pkg::REG_JRE:     cfg_jre = val;
			etfp_pkg::REG_JIM:     cfg_jim = val;
			etfp_pkg::REG_RADIUS:  cfg_radius = val[62:0];
			etfp_pkg::REG_MAXITER: cfg_maxit = val[15:0];
			etfp_pkg::REG_POWER:   cfg_power = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic add_point(input logic [63:0] re, input logic [63:0] im);
		point_t pt;
		pt.re = re;
		pt.im = im;
		point_q.push_back(pt);
	endtask

	// coordinate mostly within about +-4.0, sometimes full range
	function automatic logic [63:0] rand_coord();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) return v;
		return $signed(v) >>> $urandom_range(5, 9);
	endfunction

	task automatic add_random(input int n);
		repeat (n) add_point(rand_coord(), rand_coord());
	endtask

	// wait until the block has settled and nothing is outstanding
	task automatic drain();
		while (point_q.size() > 0 || pin.valid || pixel_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	localparam logic [63:0] ONE_FX = 64'd1 << etfp_pkg::FRAC_BITS;
	localparam logic [63:0] MAX_FX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_FX = 64'h8000_0000_0000_0000;

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		pin.valid = 1'b0;
		pin.point_re = '0;
		pin.point_im = '0;
		pout.ready = 1'b0;
		cfg_mode = 1'b0;
		cfg_jre = '0;
		cfg_jim = '0;
		cfg_radius = etfp_pkg::RADIUS_RESET;
		cfg_maxit = etfp_pkg::MAXITER_RESET;
		cfg_power = etfp_pkg::POWER_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: origin runs to the limit, extremes escape at once
		add_point(0, 0);
		add_point(MAX_FX, MAX_FX);
		add_point(MIN_FX, MIN_FX);
		add_point(MIN_FX, 0);
		add_point(2 * ONE_FX, 0);
		add_point(-(2 * ONE_FX), 0);
		add_point(0, ONE_FX);
		drain();

		// zero iteration limit
		write_reg(etfp_pkg::REG_MAXITER, 0);
		add_point(0, 0);
		add_point(MAX_FX, MIN_FX);
		drain();

		// largest limit with points that escape quickly, then limit of one
		write_reg(etfp_pkg::REG_MAXITER, 16'hFFFF);
		add_point(3 * ONE_FX, 0);
		add_point(0, -(3 * ONE_FX));
		drain();
		write_reg(etfp_pkg::REG_MAXITER, 1);
		add_point(0, 0);
		add_point(ONE_FX, ONE_FX);
		drain();

		// Mandelbrot, power 2, with one long hold-off at the output
		write_reg(etfp_pkg::REG_MAXITER, 30);
		add_random(40);
		long_hold_req = 1;
		add_random(50);
		drain();

		// Julia, power 3, including a start point whose square overflows
		write_reg(etfp_pkg::REG_MODE, 1);
		write_reg(etfp_pkg::REG_JRE, rand_coord() >>> 2);
		write_reg(etfp_pkg::REG_JIM, rand_coord() >>> 2);
		write_reg(etfp_pkg::REG_POWER, 3);
		write_reg(etfp_pkg::REG_MAXITER, 20);
		add_point(MAX_FX, 0);
		add_point(0, MIN_FX);
		add_random(60);
		drain();

		// power zero acts as power one; tiny and huge radius
		write_reg(etfp_pkg::REG_POWER, 0);
		write_reg(etfp_pkg::REG_MAXITER, 40);
		write_reg(etfp_pkg::REG_RADIUS, 1);
		add_point(0, 0);
		add_random(20);
		drain();
		write_reg(etfp_pkg::REG_RADIUS, MAX_FX);
		write_reg(etfp_pkg::REG_JRE, MIN_FX);
		write_reg(etfp_pkg::REG_JIM, MAX_FX);
		add_random(20);
		drain();

		// power beyond the maximum clamps; few iterations keep it short
		write_reg(etfp_pkg::REG_POWER, 5'd31);
		write_reg(etfp_pkg::REG_JRE, ONE_FX >>> 3);
		write_reg(etfp_pkg::REG_JIM, -(ONE_FX >>> 4));
		write_reg(etfp_pkg::REG_RADIUS, etfp_pkg::RADIUS_RESET);
		write_reg(etfp_pkg::REG_MAXITER, 6);
		add_random(25);
		drain();
		write_reg(etfp_pkg::REG_MODE, 0);
		write_reg(etfp_pkg::REG_POWER, etfp_pkg::POWER_MAX);
		write_reg(etfp_pkg::REG_RADIUS, 0);
		add_random(20);
		drain();

		// back to power 2 with a modest limit
		write_reg(etfp_pkg::REG_POWER, 2);
		write_reg(etfp_pkg::REG_RADIUS, etfp_pkg::RADIUS_RESET);
		write_reg(etfp_pkg::REG_MAXITER, 25);
		add_random(50);
		drain();

		$display("Run covered %0d points, %0d pixels checked, %0d at the limit,",
			n_points, n_pixels, n_inside);
		$display("both fractal modes, powers 0, 2, 3, 16 and 31, limits 0 to 65535.");
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(80_000_000);
		$display("CHECK FAILED");
		$finish;
	end
endmodule
